// ===== sv/mfrk_pkg.sv =====
package mfrk_pkg;

  localparam int ENTRIES    = 64;
  localparam int KEY_BITS   = 32;
  localparam int COUNT_BITS = 16;
  localparam int STAMP_BITS = 32;
  localparam int IDX_BITS   = $clog2(ENTRIES);
  localparam int SLOT_BITS  = KEY_BITS + COUNT_BITS + STAMP_BITS;

  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [KEY_BITS-1:0]   key_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [STAMP_BITS-1:0] stamp_t;

  localparam count_t COUNT_MAX = '1;
  localparam idx_t   IDX_LAST  = idx_t'(ENTRIES - 1);

  typedef enum logic {
    FN_TRADE = 1'b0,
    FN_TAKE  = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    ST_COUNTED = 2'd0,
    ST_TAKEN   = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_t;

  typedef struct packed {
    key_t   key;
    count_t count;
    stamp_t stamp;
  } slot_t;

  // control from the sequencer to the slot scanner
  typedef struct packed {
    logic start;
    logic en;
    logic slot_vld;
  } scan_ctl_t;

  // what one full pass over the table found
  typedef struct packed {
    logic   hit;
    idx_t   hit_idx;
    count_t hit_count;
    logic   free_found;
    idx_t   free_idx;
    logic   best_found;
    idx_t   best_idx;
    key_t   best_key;
    count_t best_count;
  } scan_res_t;

endpackage

// ===== sv/mfrk_ram.sv =====
module mfrk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/mfrk_scan.sv =====
module mfrk_scan (
  input  logic                clk,
  input  logic                rst_n,
  input  mfrk_pkg::scan_ctl_t ctl,
  input  mfrk_pkg::idx_t      idx,
  input  mfrk_pkg::slot_t     slot,
  input  mfrk_pkg::key_t      key,
  input  mfrk_pkg::stamp_t    seq,
  output mfrk_pkg::scan_res_t res
);
  import mfrk_pkg::*;

  scan_res_t res_r;
  scan_res_t res_nxt;
  stamp_t    best_age_r;
  stamp_t    best_age_nxt;
  stamp_t    age;
  logic      better;

  assign age    = seq - slot.stamp;
  assign better = !res_r.best_found || (slot.count > res_r.best_count) ||
                  ((slot.count == res_r.best_count) && (age < best_age_r));

  always_comb begin
    res_nxt      = res_r;
    best_age_nxt = best_age_r;
    if (ctl.start) begin
      res_nxt            = '0;
      res_nxt.hit        = 1'b0;
      res_nxt.free_found = 1'b0;
      res_nxt.best_found = 1'b0;
    end else if (ctl.en) begin
      if (ctl.slot_vld) begin
        // first matching key wins
        if (!res_r.hit && (slot.key == key)) begin
          res_nxt.hit       = 1'b1;
          res_nxt.hit_idx   = idx;
          res_nxt.hit_count = slot.count;
        end
        // strict compare keeps the lower slot on an exact tie
        if (better) begin
          res_nxt.best_found = 1'b1;
          res_nxt.best_idx   = idx;
          res_nxt.best_key   = slot.key;
          res_nxt.best_count = slot.count;
          best_age_nxt       = age;
        end
      end else if (!res_r.free_found) begin
        res_nxt.free_found = 1'b1;
        res_nxt.free_idx   = idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_r      <= '0;
      best_age_r <= '0;
    end else begin
      res_r      <= res_nxt;
      best_age_r <= best_age_nxt;
    end
  end

  assign res = res_r;

endmodule

// ===== sv/most_frequent_recent_key_tracker.sv =====
// Tracks trade counts for up to 64 keys and hands back the trending key on request: a trade
// item (func 0) counts one trade of its key unless its count is saturated, adding it with count
// 1 if unknown and a slot is free (else the result is full), and a take item (func 1) removes the
// key with the highest count, the most recently raised one among equals. Each item gives exactly
// one result on the out_ channel. Items are handled one at a time: after its transfer, the scan
// reads every slot of the slot memory once, one slot a cycle; each read is registered in the
// memory before the slot is compared, and after the last compare the memory is updated and the
// result is loaded. An item takes longer only while the previous result still waits in the output
// register. A finished result waits there while the next item is taken in. No clearing pass is
// needed after reset: slot valid bits live in flip-flops.
module most_frequent_recent_key_tracker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_func,
  input  mfrk_pkg::key_t        in_key,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [1:0]            out_status,
  output mfrk_pkg::key_t        out_key_out,
  output mfrk_pkg::count_t      out_count_out
);
  import mfrk_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t            state_r;
  idx_t              scan_r;
  logic              cmp_vld_r;
  idx_t              cmp_idx_r;
  logic              func_r;
  key_t              key_r;
  stamp_t            seq_r;
  logic [ENTRIES-1:0] valid_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  key_t              out_key_r;
  count_t            out_count_r;

  logic              in_fire;
  logic              out_free;
  logic              finish_fire;

  // slot memory ports
  logic              ram_we;
  idx_t              ram_waddr;
  slot_t             ram_wdata;
  slot_t             ram_rdata;

  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  // decision taken at the end of the scan
  logic              do_bump;
  logic              do_insert;
  count_t            bump_count;

  assign in_ready    = (state_r == S_IDLE);
  assign in_fire     = in_valid && in_ready;
  assign out_free    = !out_valid_r || out_ready;
  assign finish_fire = (state_r == S_FINISH) && out_free;

  assign out_valid     = out_valid_r;
  assign out_status    = out_status_r;
  assign out_key_out   = out_key_r;
  assign out_count_out = out_count_r;

  // Compare stage sees the slot read in the previous cycle.
  assign scan_ctl.start    = in_fire;
  assign scan_ctl.en       = cmp_vld_r;
  assign scan_ctl.slot_vld = valid_r[cmp_idx_r];

  mfrk_ram #(
    .WIDTH (SLOT_BITS),
    .DEPTH (ENTRIES)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (scan_r),
    .rdata (ram_rdata)
  );

  mfrk_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .idx   (cmp_idx_r),
    .slot  (ram_rdata),
    .key   (key_r),
    .seq   (seq_r),
    .res   (scan_res)
  );

  // Trade: bump a known key unless saturated; insert an unknown key into the lowest free slot.
  assign bump_count = scan_res.hit_count + count_t'(1);
  assign do_bump    = (func_r == FN_TRADE) && scan_res.hit &&
                      (scan_res.hit_count != COUNT_MAX);
  assign do_insert  = (func_r == FN_TRADE) && !scan_res.hit && scan_res.free_found;

  always_comb begin
    ram_we          = finish_fire && (do_bump || do_insert);
    ram_waddr       = do_bump ? scan_res.hit_idx : scan_res.free_idx;
    ram_wdata.key   = key_r;
    ram_wdata.count = do_bump ? bump_count : count_t'(1);
    ram_wdata.stamp = seq_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      scan_r       <= '0;
      cmp_vld_r    <= 1'b0;
      cmp_idx_r    <= '0;
      seq_r        <= '0;
      valid_r      <= '0;
      out_valid_r  <= 1'b0;
      out_status_r <= ST_COUNTED;
      out_key_r    <= '0;
      out_count_r  <= '0;
      func_r       <= 1'b0;
      key_r        <= '0;
    end else begin
      // drop the result once it transfers, unless the next one loads now
      if (out_valid_r && out_ready && !finish_fire) begin
        out_valid_r <= 1'b0;
      end

      // read pipeline: slot index is registered alongside the read data so the two stay aligned
      cmp_vld_r <= (state_r == S_SCAN);
      cmp_idx_r <= scan_r;

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            func_r  <= in_func;
            key_r   <= in_key;
            scan_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // advance through every slot, one read a cycle
          if (scan_r == IDX_LAST) begin
            state_r <= S_DRAIN;
          end else begin
            scan_r <= scan_r + idx_t'(1);
          end
        end
        S_DRAIN: begin
          // last slot is compared this cycle
          state_r <= S_FINISH;
        end
        S_FINISH: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
            if (func_r == FN_TRADE) begin
              out_key_r <= '0;
              if (scan_res.hit) begin
                out_status_r <= ST_COUNTED;
                out_count_r  <= do_bump ? bump_count : scan_res.hit_count;
                if (do_bump) begin
                  seq_r <= seq_r + stamp_t'(1);
                end
              end else if (scan_res.free_found) begin
                out_status_r                <= ST_COUNTED;
                out_count_r                 <= count_t'(1);
                valid_r[scan_res.free_idx]  <= 1'b1;
                seq_r                       <= seq_r + stamp_t'(1);
              end else begin
                out_status_r <= ST_FULL;
                out_count_r  <= '0;
              end
            end else begin
              if (scan_res.best_found) begin
                out_status_r               <= ST_TAKEN;
                out_key_r                  <= scan_res.best_key;
                out_count_r                <= scan_res.best_count;
                valid_r[scan_res.best_idx] <= 1'b0;
              end else begin
                out_status_r <= ST_EMPTY;
                out_key_r    <= '0;
                out_count_r  <= '0;
              end
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== sv/mfrk_checker.sv =====
module mfrk_checker (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [1:0]       out_status,
  input mfrk_pkg::key_t   out_key_out,
  input mfrk_pkg::count_t out_count_out
);
  import mfrk_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_key_out) && $stable(out_count_out))
    else $error("stalled result changed");

  // one item at a time: no transfer right after a transfer
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while an item is in flight");

  // only a take carries a key
  a_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_TAKEN) |-> out_key_out == '0)
    else $error("key on a result that is not a take");

  // counted and taken results carry a count, empty and full ones do not
  a_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_status == ST_COUNTED) || (out_status == ST_TAKEN)) ==
                   (out_count_out != '0)))
    else $error("count does not match status");

endmodule

bind most_frequent_recent_key_tracker mfrk_checker u_mfrk_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_status    (out_status),
  .out_key_out   (out_key_out),
  .out_count_out (out_count_out)
);
